// File: src/ct3_pkg.sv
// Shared sizes, register indexes and clamp limits for the 3x3 census transform.
// No dependencies; used by census_transform_3x3 and its checker.
`default_nettype none

package ct3_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int PIX_W        = 8;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int WID_W        = 12;
    localparam int HGT_W        = 13;
    localparam int CFG_W        = 13;
    localparam int IDX_W        = 2;
    localparam int CODE_W       = 8;

    localparam logic [IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [WID_W-1:0] WID_MIN = WID_W'(3);
    localparam logic [WID_W-1:0] WID_MAX = WID_W'(MAX_WIDTH);
    localparam logic [HGT_W-1:0] HGT_MIN = HGT_W'(3);
    localparam logic [HGT_W-1:0] HGT_MAX = HGT_W'(HEIGHT_LIMIT);

endpackage

`default_nettype wire

// File: src/census_transform_3x3.sv
// 3x3 census transform over a raster pixel stream, with line store and window.
// Depends on ct3_pkg.
`default_nettype none

// One pixel request is taken per clock when the output side keeps up. The line
// store is a single synchronous memory, one entry per column holding the two
// rows above; a pixel reads its column when accepted and writes it back as it
// leaves stage one while the window shifts, and its census code enters the
// output register. Consecutive pixels always touch different columns, so no
// forwarding is needed. Border pixels give no result; the last code of a frame
// carries o_frame_end. A configuration write restarts the frame at row 0,
// column 0 and must be made while the block is idle.
module census_transform_3x3 (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [ct3_pkg::IDX_W-1:0]      i_cfg_index,
    input  wire  [ct3_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [ct3_pkg::PIX_W-1:0]      i_pixel,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [ct3_pkg::CODE_W-1:0]     o_census_code,
    output logic [ct3_pkg::COL_W-1:0]      o_center_x,
    output logic [ct3_pkg::ROW_W-1:0]      o_center_y,
    output logic                           o_frame_end
);

    localparam int PW = ct3_pkg::PIX_W;
    localparam int CW = ct3_pkg::COL_W;
    localparam int RW = ct3_pkg::ROW_W;

    // line store: upper half is two rows above, lower half is row above
    logic [2*PW-1:0] r_line_mem [0:ct3_pkg::MAX_WIDTH-1];

    logic [CW-1:0] r_col_last, n_col_last;
    logic [RW-1:0] r_row_last, n_row_last;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic          r_s1_valid;
    logic [PW-1:0] r_s1_pix;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic [PW-1:0] r_top, r_mid;

    logic [PW-1:0] r_win [0:5];

    logic          in_acc, s1_adv, s1_res;
    logic [ct3_pkg::CODE_W-1:0] n_code;
    logic [PW-1:0] nb [0:7];
    logic [ct3_pkg::WID_W-1:0] cfg_w;
    logic [ct3_pkg::HGT_W-1:0] cfg_h, h_eff;
    logic [ct3_pkg::WID_W-1:0] w_eff;

    assign s1_res = r_s1_valid && (r_s1_row >= RW'(2)) && (r_s1_col >= CW'(2));
    assign s1_adv = r_s1_valid && (!s1_res || !o_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc = i_in_valid && !o_in_stall;

    // clamp the register values once, at write time
    always_comb begin
        cfg_w = i_cfg_data[ct3_pkg::WID_W-1:0];
        cfg_h = i_cfg_data[ct3_pkg::HGT_W-1:0];
        if (cfg_w < ct3_pkg::WID_MIN) begin
            w_eff = ct3_pkg::WID_MIN;
        end else if (cfg_w > ct3_pkg::WID_MAX) begin
            w_eff = ct3_pkg::WID_MAX;
        end else begin
            w_eff = cfg_w;
        end
        if (cfg_h < ct3_pkg::HGT_MIN) begin
            h_eff = ct3_pkg::HGT_MIN;
        end else if (cfg_h > ct3_pkg::HGT_MAX) begin
            h_eff = ct3_pkg::HGT_MAX;
        end else begin
            h_eff = cfg_h;
        end
        n_col_last = r_col_last;
        n_row_last = r_row_last;
        if (i_cfg_we && i_cfg_index == ct3_pkg::REG_LINE_WIDTH) begin
            n_col_last = CW'(w_eff - ct3_pkg::WID_W'(1));
        end
        if (i_cfg_we && i_cfg_index == ct3_pkg::REG_FRAME_HEIGHT) begin
            n_row_last = RW'(h_eff - ct3_pkg::HGT_W'(1));
        end
    end

    always_comb begin
        nb[0] = r_win[0];
        nb[1] = r_win[3];
        nb[2] = r_top;
        nb[3] = r_win[1];
        nb[4] = r_mid;
        nb[5] = r_win[2];
        nb[6] = r_win[5];
        nb[7] = r_s1_pix;
        for (int i = 0; i < 8; i++) begin
            n_code[i] = nb[i] > r_win[4];
        end
    end

    // frame position of the next request and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= CW'(ct3_pkg::MAX_WIDTH - 1);
            r_row_last <= RW'(2047);
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            r_col_last <= n_col_last;
            r_row_last <= n_row_last;
            if (i_cfg_we && (i_cfg_index == ct3_pkg::REG_LINE_WIDTH ||
                             i_cfg_index == ct3_pkg::REG_FRAME_HEIGHT)) begin
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc) begin
                if (r_col == r_col_last) begin
                    r_col <= '0;
                    r_row <= (r_row == r_row_last) ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // read on accept, write back as the request leaves stage one
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            {r_top, r_mid} <= r_line_mem[r_col];
        end
        if (s1_adv) begin
            r_line_mem[r_s1_col] <= {r_mid, r_s1_pix};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= r_top;
                r_win[4] <= r_mid;
                r_win[5] <= r_s1_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= i_pixel;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_adv && s1_res) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_res) begin
            o_census_code <= n_code;
            o_center_x    <= r_s1_col - CW'(1);
            o_center_y    <= r_s1_row - RW'(1);
            o_frame_end   <= (r_s1_col == r_col_last) && (r_s1_row == r_row_last);
        end
    end

endmodule

`default_nettype wire

// File: src/ct3_chk.sv
// Port-level checker for census_transform_3x3, attached by bind.
// Depends on ct3_pkg.
`default_nettype none

module ct3_chk (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            i_cfg_we,
    input wire [ct3_pkg::IDX_W-1:0]       i_cfg_index,
    input wire [ct3_pkg::CFG_W-1:0]       i_cfg_data,
    input wire                            i_in_valid,
    input wire                            o_in_stall,
    input wire [ct3_pkg::PIX_W-1:0]       i_pixel,
    input wire                            o_out_valid,
    input wire                            i_out_stall,
    input wire [ct3_pkg::CODE_W-1:0]      o_census_code,
    input wire [ct3_pkg::COL_W-1:0]       o_center_x,
    input wire [ct3_pkg::ROW_W-1:0]       o_center_y,
    input wire                            o_frame_end
);

    // a held result keeps its place
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_census_code)))
        else $error("result dropped or changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

    // a border centre never reaches the output
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_center_x != '0 && o_center_y != '0 &&
                         o_center_x != '1 && o_center_y != '1))
        else $error("border centre reported");

    // stage one never holds while the output register is free
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && i_rst_n) |-> !o_in_stall)
        else $error("input stalled with empty output");

endmodule

bind census_transform_3x3 ct3_chk u_ct3_chk (.*);

`default_nettype wire
